>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("grid ray clearance check failed");

// property that must also hold across reset
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("grid ray clearance reset check failed");

`endif

>>> rtl/grc_pkg.sv
package grc_pkg;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [7:0] OPEN_LEVEL_RESET = 8'd128;

   typedef enum logic [1:0] {
      DIV_ROW,
      DIV_COL,
      DIV_DIST
   } div_sel_type;

   typedef struct packed {
      logic        load_cast;
      logic        wr_cell;
      logic        sq_first;
      logic        sq_second;
      logic        root_init;
      logic        root_step;
      logic        div_go;
      div_sel_type div_sel;
      logic        march_init;
      logic        march_step;
      logic        mul_dist;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic div_done;
      logic march_hit;
      logic march_clear;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/grid_ray_clearance_unit.sv
// channel   direction  handshake          payload
// req_      in         valid / stall      operation, start/end row+col, cell_value
// rsp_      out        valid / stall      clear_distance, blocked
// csr_      in         valid / ready      data (open level)
//
// a cell write does not stall; the next item may follow at once
// a cast holds req_stall while it runs: two squares, the bit-serial square root,
//   a restoring divide of NW = max(FRAC_BITS + 8, 25) bits for each of the two
//   increments (plus the distance on a block), and one grid read a cycle over
//   the march (steps up to 361)
// synchronous active-high reset clears control and sets open level to 128; the
//   grid memory is not cleared and holds nothing until written
// a finished result sits in the output register, so a stalled rsp_ side does
//   not block the next transfer in until another cast completes
module grid_ray_clearance_unit #(
   parameter int GRID_ROWS = 256,
   parameter int GRID_COLS = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_start_row,
   input  logic [7:0]  req_start_col,
   input  logic [7:0]  req_end_row,
   input  logic [7:0]  req_end_col,
   input  logic [7:0]  req_cell_value,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_clear_distance,
   output logic        rsp_blocked,
   // open level register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   grc_pkg::cmd_type    cmd;
   grc_pkg::status_type status;

   // register writes must arrive only while idle (the block does not check), so always take them
   assign csr_ready = 1'b1;

   // sequencer: square root, increments, march, distance divide
   grc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // grid memory, arithmetic and result register
   grc_dp #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_start_row      (req_start_row),
      .req_start_col      (req_start_col),
      .req_end_row        (req_end_row),
      .req_end_col        (req_end_col),
      .req_cell_value     (req_cell_value),
      .csr_valid          (csr_valid && csr_ready),
      .csr_data           (csr_data),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_clear_distance (rsp_clear_distance),
      .rsp_blocked        (rsp_blocked)
   );

endmodule

>>> rtl/grc_div.sv
module grc_div #(
   parameter int NW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [8:0]    denom,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [8:0]    rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [9:0]    trial;
   logic          fits;

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff, num_ff[NW-1]};
   assign fits  = trial >= {1'b0, denom};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         rem_in  = 9'd0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 9'(trial - {1'b0, denom}) : trial[8:0];
         num_in = {num_ff[NW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

>>> rtl/grc_ctrl.sv
module grc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_stall,
   output grc_pkg::cmd_type    cmd,
   input  grc_pkg::status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_A,
      S_SQ_B,
      S_ROOT_INIT,
      S_ROOT,
      S_DIVR_GO,
      S_DIVR_WAIT,
      S_DIVC_GO,
      S_DIVC_WAIT,
      S_MARCH_INIT,
      S_MARCH,
      S_MUL,
      S_DIVD_GO,
      S_DIVD_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = grc_pkg::DIV_ROW;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == grc_pkg::OP_CAST) begin
                  cmd.load_cast = 1'b1;
                  state_in      = S_SQ_A;
               end else begin
                  cmd.wr_cell = 1'b1;
               end
            end
         end
         S_SQ_A: begin
            cmd.sq_first = 1'b1;
            state_in     = S_SQ_B;
         end
         S_SQ_B: begin
            cmd.sq_second = 1'b1;
            state_in      = S_ROOT_INIT;
         end
         S_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_done) begin
               state_in = S_DIVR_GO;
            end
         end
         S_DIVR_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = grc_pkg::DIV_ROW;
            state_in    = S_DIVR_WAIT;
         end
         S_DIVR_WAIT: begin
            cmd.div_sel = grc_pkg::DIV_ROW;
            if (status.div_done) begin
               state_in = S_DIVC_GO;
            end
         end
         S_DIVC_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = grc_pkg::DIV_COL;
            state_in    = S_DIVC_WAIT;
         end
         S_DIVC_WAIT: begin
            cmd.div_sel = grc_pkg::DIV_COL;
            if (status.div_done) begin
               state_in = S_MARCH_INIT;
            end
         end
         S_MARCH_INIT: begin
            cmd.march_init = 1'b1;
            state_in       = S_MARCH;
         end
         S_MARCH: begin
            cmd.march_step = 1'b1;
            if (status.march_hit) begin
               state_in = S_MUL;
            end else if (status.march_clear) begin
               state_in = S_FINISH;
            end
         end
         S_MUL: begin
            cmd.mul_dist = 1'b1;
            state_in     = S_DIVD_GO;
         end
         S_DIVD_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = grc_pkg::DIV_DIST;
            state_in    = S_DIVD_WAIT;
         end
         S_DIVD_WAIT: begin
            cmd.div_sel = grc_pkg::DIV_DIST;
            if (status.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/grc_dp.sv
module grc_dp #(
   parameter int GRID_ROWS = 256,
   parameter int GRID_COLS = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  grc_pkg::cmd_type    cmd,
   output grc_pkg::status_type status,
   input  logic [7:0]          req_start_row,
   input  logic [7:0]          req_start_col,
   input  logic [7:0]          req_end_row,
   input  logic [7:0]          req_end_col,
   input  logic [7:0]          req_cell_value,
   input  logic                csr_valid,
   input  logic [7:0]          csr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [15:0]         rsp_clear_distance,
   output logic                rsp_blocked
);

   localparam int ROW_SPAN = (GRID_ROWS < 256) ? GRID_ROWS : 256;
   localparam int COL_SPAN = (GRID_COLS < 256) ? GRID_COLS : 256;
   localparam int RAB = $clog2(ROW_SPAN);
   localparam int CAB = $clog2(COL_SPAN);
   localparam int AW  = RAB + CAB;
   localparam int OW  = FRAC_BITS + 10;
   localparam int NW  = (FRAC_BITS + 8 > 25) ? FRAC_BITS + 8 : 25;
   localparam logic [12:0] ROWS13 = 13'(GRID_ROWS);
   localparam logic [12:0] COLS13 = 13'(GRID_COLS);

   logic [7:0] mem [0:(2**AW)-1];

   logic [7:0]          open_ff;
   logic [7:0]          r1_ff, c1_ff;
   logic signed [8:0]   dr_ff, dc_ff;
   logic [16:0]         sq_ff;
   logic [31:0]         v_ff, res_ff, bit_ff;
   logic signed [OW-1:0] inc_r_ff, inc_c_ff, off_r_ff, off_c_ff;
   logic [8:0]          issue_ff;
   logic                rd_valid_ff, rd_out_ff;
   logic [8:0]          rd_idx_ff;
   logic [7:0]          mem_q_ff;
   logic                hit_ff;
   logic [8:0]          hit_idx_ff;
   logic [24:0]         prod_ff;
   logic [15:0]         dist_ff;
   logic                rsp_valid_ff;
   logic [15:0]         rsp_dist_ff;
   logic                rsp_blk_ff;

   logic [15:0]         len;
   logic [8:0]          steps;
   logic signed [8:0]   mul_op;
   logic signed [17:0]  sq_prod;
   logic [31:0]         root_sum;
   logic [7:0]          abs_dr, abs_dc;
   logic [NW-1:0]       div_numer, div_quot;
   logic                div_done;
   logic signed [OW-1:0] inc_mag;
   logic                inc_neg;
   logic signed [9:0]   trunc_r, trunc_c;
   logic [7:0]          smp_row, smp_col;
   logic                smp_ok, wr_ok;
   logic                issue_en;
   logic                cell_blocks;

   // integer part of an offset, truncated toward zero
   function automatic logic signed [9:0] trunc_off(input logic signed [OW-1:0] x);
      logic [OW-1:0] mag;
      logic [9:0]    ip;
      mag = x[OW-1] ? OW'(-x) : OW'(x);
      ip  = mag[FRAC_BITS +: 10];
      return x[OW-1] ? -$signed(ip) : $signed(ip);
   endfunction

   assign len   = res_ff[15:0];
   assign steps = 9'(len[15:7] + 9'd1);

   assign mul_op  = cmd.sq_first ? dr_ff : dc_ff;
   assign sq_prod = mul_op * mul_op;
   assign root_sum = res_ff + bit_ff;

   assign abs_dr = dr_ff[8] ? 8'(-dr_ff) : dr_ff[7:0];
   assign abs_dc = dc_ff[8] ? 8'(-dc_ff) : dc_ff[7:0];

   always_comb begin
      case (cmd.div_sel)
         grc_pkg::DIV_ROW:  div_numer = NW'(abs_dr) << FRAC_BITS;
         grc_pkg::DIV_COL:  div_numer = NW'(abs_dc) << FRAC_BITS;
         grc_pkg::DIV_DIST: div_numer = NW'(prod_ff);
         default:           div_numer = '0;
      endcase
   end

   grc_div #(.NW(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .numer (div_numer),
      .denom (steps),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign inc_mag = OW'(div_quot);
   assign inc_neg = (cmd.div_sel == grc_pkg::DIV_ROW) ? dr_ff[8] : dc_ff[8];

   // sample position of the next read
   assign trunc_r = trunc_off(off_r_ff);
   assign trunc_c = trunc_off(off_c_ff);
   assign smp_row = 8'($signed({2'b00, r1_ff}) + trunc_r);
   assign smp_col = 8'($signed({2'b00, c1_ff}) + trunc_c);
   assign smp_ok  = ({5'd0, smp_row} < ROWS13) && ({5'd0, smp_col} < COLS13);
   assign wr_ok   = ({5'd0, req_start_row} < ROWS13) && ({5'd0, req_start_col} < COLS13);
   assign issue_en = cmd.march_step && (issue_ff != steps);

   // a cell outside the grid reads as zero
   assign cell_blocks = rd_out_ff ? (open_ff != 8'd0) : (mem_q_ff < open_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_cell && wr_ok) begin
         mem[{req_start_row[RAB-1:0], req_start_col[CAB-1:0]}] <= req_cell_value;
      end
      if (issue_en) begin
         mem_q_ff <= mem[{smp_row[RAB-1:0], smp_col[CAB-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cast) begin
         r1_ff <= req_start_row;
         c1_ff <= req_start_col;
         dr_ff <= $signed({1'b0, req_end_row}) - $signed({1'b0, req_start_row});
         dc_ff <= $signed({1'b0, req_end_col}) - $signed({1'b0, req_start_col});
      end
      if (cmd.sq_first) begin
         sq_ff <= sq_prod[16:0];
      end else if (cmd.sq_second) begin
         sq_ff <= 17'(sq_ff + sq_prod[16:0]);
      end
      if (cmd.root_init) begin
         v_ff   <= {1'b0, sq_ff, 14'd0};
         res_ff <= 32'd0;
         bit_ff <= 32'd1 << 30;
      end else if (cmd.root_step && (bit_ff != 32'd0)) begin
         if (v_ff >= root_sum) begin
            v_ff   <= v_ff - root_sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (div_done) begin
         case (cmd.div_sel)
            grc_pkg::DIV_ROW:  inc_r_ff <= inc_neg ? -inc_mag : inc_mag;
            grc_pkg::DIV_COL:  inc_c_ff <= inc_neg ? -inc_mag : inc_mag;
            grc_pkg::DIV_DIST: dist_ff  <= div_quot[15:0];
            default:           dist_ff  <= dist_ff;
         endcase
      end
      if (cmd.march_init) begin
         off_r_ff <= OW'(1) <<< (FRAC_BITS - 1);
         off_c_ff <= OW'(1) <<< (FRAC_BITS - 1);
         issue_ff <= 9'd0;
      end else if (issue_en) begin
         off_r_ff  <= off_r_ff + inc_r_ff;
         off_c_ff  <= off_c_ff + inc_c_ff;
         issue_ff  <= issue_ff + 9'd1;
         rd_idx_ff <= issue_ff;
         rd_out_ff <= !smp_ok;
      end
      if (cmd.march_step && status.march_hit) begin
         hit_idx_ff <= rd_idx_ff;
      end
      if (cmd.mul_dist) begin
         prod_ff <= hit_idx_ff * len;
      end
      if (cmd.rsp_load) begin
         rsp_dist_ff <= hit_ff ? dist_ff : len;
         rsp_blk_ff  <= hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= grc_pkg::OPEN_LEVEL_RESET;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            open_ff <= csr_data;
         end
         if (cmd.march_init) begin
            rd_valid_ff <= 1'b0;
            hit_ff      <= 1'b0;
         end else if (cmd.march_step) begin
            rd_valid_ff <= issue_en;
            if (status.march_hit) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.root_done   = (bit_ff == 32'd0);
   assign status.div_done    = div_done;
   assign status.march_hit   = rd_valid_ff && cell_blocks;
   assign status.march_clear = rd_valid_ff && !cell_blocks && (rd_idx_ff == steps - 9'd1);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clear_distance = rsp_dist_ff;
   assign rsp_blocked        = rsp_blk_ff;

endmodule

>>> rtl/grc_checker.sv
`include "assert_macros.svh"

module grc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_clear_distance,
   input logic        rsp_blocked
);

   logic write_xfer, cast_xfer, rsp_held;

   assign write_xfer = req_valid && !req_stall && (req_operation == grc_pkg::OP_WRITE);
   assign cast_xfer  = req_valid && !req_stall && (req_operation == grc_pkg::OP_CAST);
   assign rsp_held   = rsp_valid && rsp_stall;

   `CHK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !req_stall && !rsp_valid)
   `CHK_ASSERT(a_write_single, clock, reset, write_xfer |=> !req_stall)
   `CHK_ASSERT(a_cast_busy, clock, reset, cast_xfer |=> req_stall)
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid)
   `CHK_ASSERT(a_rsp_stable, clock, reset, rsp_held |=> $stable({rsp_clear_distance, rsp_blocked}))

endmodule

bind grid_ray_clearance_unit grc_checker u_grc_checker (.*);

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = 256;
   localparam int COLS = 256;
   localparam int FB = 16;
   localparam int PATCH = 12;
   localparam int STALL_LIMIT = 200000;

   typedef struct packed {
      logic       operation;
      logic [7:0] start_row;
      logic [7:0] start_col;
      logic [7:0] end_row;
      logic [7:0] end_col;
      logic [7:0] cell_value;
   } ray_item_type;

   typedef struct packed {
      logic [15:0] distance;
      logic        blocked;
   } clearance_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [7:0] req_start_row = '0, req_start_col = '0, req_end_row = '0;
   logic [7:0] req_end_col = '0, req_cell_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_clear_distance;
   logic rsp_blocked;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   grid_ray_clearance_unit dut (.*);

   always #5 clock = ~clock;

   // stimulus queue, expected clearances, shadow grid and planned grid
   ray_item_type  pending_items[$];
   clearance_type expected_clearances[$];
   logic [7:0] shadow_grid[int];
   logic [7:0] planned_grid[int];
   logic [7:0] shadow_open_level = grc_pkg::OPEN_LEVEL_RESET;
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit idle_free = 1'b0;   // long stretch with no idling on either side

   // integer square root by restoring bits
   function automatic int unsigned int_root(int unsigned v);
      int unsigned res, bitv;
      res = 0;
      bitv = 32'h4000_0000;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint trunc_offset(longint x);
      if (x >= 0) return x >>> FB;
      return -((-x) >>> FB);
   endfunction

   function automatic logic [7:0] cell_at(longint r, longint c);
      int key;
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 8'd0;
      key = int'(r) * COLS + int'(c);
      return shadow_grid.exists(key) ? shadow_grid[key] : 8'd0;
   endfunction

   // march the ray over the shadow grid and work out its clearance
   function automatic clearance_type cast_clearance(ray_item_type it);
      clearance_type res;
      longint dr, dc, inc_r, inc_c, half, ro, co;
      int unsigned len, steps;
      dr = longint'(it.end_row) - longint'(it.start_row);
      dc = longint'(it.end_col) - longint'(it.start_col);
      len = int_root(int'(dr * dr + dc * dc) << 14);
      steps = (len >> 7) + 1;
      half = 64'sd1 <<< (FB - 1);
      inc_r = (dr * (64'sd1 <<< FB)) / longint'(steps);
      inc_c = (dc * (64'sd1 <<< FB)) / longint'(steps);
      res.distance = len[15:0];
      res.blocked = 1'b0;
      for (int i = 0; i < steps; i++) begin
         ro = half + longint'(i) * inc_r;
         co = half + longint'(i) * inc_c;
         if (cell_at(it.start_row + trunc_offset(ro), it.start_col + trunc_offset(co))
             < shadow_open_level) begin
            res.distance = 16'((longint'(i) * len) / steps);
            res.blocked = 1'b1;
            return res;
         end
      end
      return res;
   endfunction

   // every cell the cast reads, up to where it stops, has been planned as written
   function automatic bit cast_reads_written(ray_item_type it);
      longint dr, dc, inc_r, inc_c, half, r, c;
      int unsigned len, steps;
      int key;
      dr = longint'(it.end_row) - longint'(it.start_row);
      dc = longint'(it.end_col) - longint'(it.start_col);
      len = int_root(int'(dr * dr + dc * dc) << 14);
      steps = (len >> 7) + 1;
      half = 64'sd1 <<< (FB - 1);
      inc_r = (dr * (64'sd1 <<< FB)) / longint'(steps);
      inc_c = (dc * (64'sd1 <<< FB)) / longint'(steps);
      for (int i = 0; i < steps; i++) begin
         r = it.start_row + trunc_offset(half + longint'(i) * inc_r);
         c = it.start_col + trunc_offset(half + longint'(i) * inc_c);
         key = int'(r) * COLS + int'(c);
         if (!planned_grid.exists(key)) return 1'b0;
         if (planned_grid[key] < shadow_open_level) return 1'b1;
      end
      return 1'b1;
   endfunction

   // driver: one transfer in at a time, payload held while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            ray_item_type done_item;
            done_item = {req_operation, req_start_row, req_start_col,
                         req_end_row, req_end_col, req_cell_value};
            // predict at acceptance, in order, against the shadow grid
            if (done_item.operation == grc_pkg::OP_WRITE)
               shadow_grid[int'(done_item.start_row) * COLS + int'(done_item.start_col)] =
                  done_item.cell_value;
            else
               expected_clearances.push_back(cast_clearance(done_item));
         end
         if ((!req_valid || !req_stall)) begin
            if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 35)) begin
               ray_item_type it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               {req_operation, req_start_row, req_start_col, req_end_row,
                req_end_col, req_cell_value} <= it;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall at random, compare each transfer out with the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            clearance_type want;
            if (expected_clearances.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: distance %0d blocked %0b",
                           rsp_clear_distance, rsp_blocked);
            end else begin
               want = expected_clearances.pop_front();
               if (rsp_clear_distance !== want.distance || rsp_blocked !== want.blocked) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected distance %0d blocked %0b, got %0d %0b",
                              want.distance, want.blocked, rsp_clear_distance, rsp_blocked);
               end
            end
         end
         rsp_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 35);
      end
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic ray_item_type write_item(int r, int c, int v);
      ray_item_type it;
      it = '0;
      it.operation = grc_pkg::OP_WRITE;
      it.start_row = 8'(r);
      it.start_col = 8'(c);
      it.end_row = 8'($urandom);
      it.end_col = 8'($urandom);
      it.cell_value = 8'(v);
      return it;
   endfunction

   function automatic ray_item_type cast_item(int r1, int c1, int r2, int c2);
      ray_item_type it;
      it.operation = grc_pkg::OP_CAST;
      it.start_row = 8'(r1);
      it.start_col = 8'(c1);
      it.end_row = 8'(r2);
      it.end_col = 8'(c2);
      it.cell_value = 8'($urandom);
      return it;
   endfunction

   // wait until the queue has drained and the block has gone quiet
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_clearances.size() > 0)
         @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_open_level(logic [7:0] level);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= level;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_open_level = level;
   endtask

   // the planned grid follows queue order, so it matches the grid at acceptance
   task automatic plan_write(int r, int c, int v);
      pending_items.push_back(write_item(r, c, v));
      planned_grid[r * COLS + c] = 8'(v);
   endtask

   task automatic queue_cast(int r1, int c1, int r2, int c2);
      pending_items.push_back(cast_item(r1, c1, r2, c2));
   endtask

   // random cast that reads only written cells: now and then a long ray that must
   // stop on a blocking cell, otherwise one inside the written patch
   task automatic queue_random_cast();
      ray_item_type it;
      int tries, r2, c2;
      tries = 0;
      if ($urandom_range(4) == 0) begin
         do begin
            r2 = $urandom_range(255, PATCH);
            case ($urandom_range(2))
               0:       c2 = r2;
               1:       c2 = 0;
               default: c2 = $urandom_range(255);
            endcase
            it = cast_item(0, 0, r2, c2);
            tries++;
         end while (!cast_reads_written(it) && tries < 20);
         if (cast_reads_written(it)) begin
            pending_items.push_back(it);
            return;
         end
      end
      it = cast_item($urandom_range(PATCH - 1), $urandom_range(PATCH - 1),
                     $urandom_range(PATCH - 1), $urandom_range(PATCH - 1));
      pending_items.push_back(it);
   endtask

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill a small patch at the origin, with blocking cells just past it on
      // the diagonal and both edges so long rays from the origin stop there
      for (int r = 0; r < PATCH; r++)
         for (int c = 0; c < PATCH; c++)
            plan_write(r, c, 200);
      plan_write(PATCH, PATCH, 0);
      plan_write(0, PATCH, 0);
      plan_write(PATCH, 0, 0);
      drain();

      // directed: degenerate ray, long blocked rays, blocking cells in the patch
      queue_cast(5, 5, 5, 5);
      plan_write(6, 6, 0);
      queue_cast(6, 6, 6, 6);
      queue_cast(0, 0, 255, 255);
      queue_cast(0, 0, 0, 255);
      queue_cast(0, 0, 255, 0);
      queue_cast(11, 11, 0, 0);
      queue_cast(0, 0, 11, 11);
      plan_write(5, 7, 127);
      plan_write(3, 3, 128);
      queue_cast(0, 0, 11, 10);
      queue_cast(11, 0, 0, 11);
      queue_cast(3, 0, 3, 11);
      queue_cast(0, 7, 11, 7);
      drain();

      write_open_level(8'd0);
      queue_cast(6, 6, 6, 6);
      queue_cast(0, 0, 11, 11);
      drain();
      write_open_level(8'd255);
      queue_cast(0, 0, 255, 255);
      queue_cast(3, 9, 11, 2);
      drain();
      write_open_level(grc_pkg::OPEN_LEVEL_RESET);

      // random phases over several levels; the third one without idling
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1) write_open_level(8'($urandom));
         if (phase == 3) write_open_level(8'd1);
         idle_free = (phase == 2);
         for (n = 0; n < 60; n++) begin
            if ($urandom_range(1))
               plan_write($urandom_range(PATCH - 1), $urandom_range(PATCH - 1), $urandom);
            else
               queue_random_cast();
         end
         drain();
      end
      idle_free = 1'b0;

      if (mismatch_count == 0 && expected_clearances.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
